// ===== rtl/core/wasws_pkg.sv =====
// Shared types and codes for the word ALU with shift spill.
`timescale 1ns / 1ps
package wasws_pkg;

	localparam logic [3:0] MODE_AND = 4'd0;
	localparam logic [3:0] MODE_OR  = 4'd1;
	localparam logic [3:0] MODE_NOT = 4'd2;
	localparam logic [3:0] MODE_NEG = 4'd3;
	localparam logic [3:0] MODE_CMP = 4'd4;
	localparam logic [3:0] MODE_ADD = 4'd5;
	localparam logic [3:0] MODE_SUB = 4'd6;
	localparam logic [3:0] MODE_MUL = 4'd7;
	localparam logic [3:0] MODE_DIV = 4'd8;
	localparam logic [3:0] MODE_MOD = 4'd9;
	localparam logic [3:0] MODE_SHL = 4'd10;
	localparam logic [3:0] MODE_SHR = 4'd11;
	localparam logic [3:0] MODE_SAR = 4'd12;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_CARRY   = 3'd1;
	localparam logic [2:0] ST_BORROW  = 3'd2;
	localparam logic [2:0] ST_DIVZ    = 3'd3;
	localparam logic [2:0] ST_MODZ    = 3'd4;
	localparam logic [2:0] ST_COUNT   = 3'd5;
	localparam logic [2:0] ST_ONEWORD = 3'd6;
	localparam logic [2:0] ST_TWOWORD = 3'd7;

	localparam logic [1:0] ORD_LESS    = 2'd0;
	localparam logic [1:0] ORD_EQUAL   = 2'd1;
	localparam logic [1:0] ORD_GREATER = 2'd2;

	localparam int COUNT_BITS = 6;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_AND,
		OP_OR,
		OP_NOT,
		OP_NEG,
		OP_CMP,
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV,
		OP_MOD,
		OP_SHL,
		OP_SHR,
		OP_SAR
	} op_t;

	typedef struct packed {
		op_t  op;
		logic cnt_err;
		logic zero_div;
	} ctrl_t;

endpackage

// ===== rtl/core/wasws_front.sv =====
// Input side: decode the mode, flag bad counts and zero divisors.
`timescale 1ns / 1ps
module wasws_front #(
	parameter int WORD_BITS = 32
) (
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [3:0]              mode,
	input  logic [WORD_BITS-1:0]    operand_b,
	input  logic [wasws_pkg::COUNT_BITS-1:0] shift_amt,
	input  logic                    q_full,
	output logic                    push,
	output wasws_pkg::ctrl_t        ctrl
);

	localparam logic [wasws_pkg::COUNT_BITS:0] MAX_CNT = (wasws_pkg::COUNT_BITS+1)'(WORD_BITS - 1);

	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full;

	always_comb begin
		unique case (mode)
			wasws_pkg::MODE_AND: ctrl.op = wasws_pkg::OP_AND;
			wasws_pkg::MODE_OR:  ctrl.op = wasws_pkg::OP_OR;
			wasws_pkg::MODE_NOT: ctrl.op = wasws_pkg::OP_NOT;
			wasws_pkg::MODE_NEG: ctrl.op = wasws_pkg::OP_NEG;
			wasws_pkg::MODE_CMP: ctrl.op = wasws_pkg::OP_CMP;
			wasws_pkg::MODE_ADD: ctrl.op = wasws_pkg::OP_ADD;
			wasws_pkg::MODE_SUB: ctrl.op = wasws_pkg::OP_SUB;
			wasws_pkg::MODE_MUL: ctrl.op = wasws_pkg::OP_MUL;
			wasws_pkg::MODE_DIV: ctrl.op = wasws_pkg::OP_DIV;
			wasws_pkg::MODE_MOD: ctrl.op = wasws_pkg::OP_MOD;
			wasws_pkg::MODE_SHL: ctrl.op = wasws_pkg::OP_SHL;
			wasws_pkg::MODE_SHR: ctrl.op = wasws_pkg::OP_SHR;
			wasws_pkg::MODE_SAR: ctrl.op = wasws_pkg::OP_SAR;
			default:             ctrl.op = wasws_pkg::OP_NONE;
		endcase
		ctrl.cnt_err  = {1'b0, shift_amt} > MAX_CNT;
		ctrl.zero_div = (operand_b == '0);
	end

endmodule

// ===== rtl/core/wasws_queue.sv =====
// Two-entry queue between the decode side and the execute pipeline.
`timescale 1ns / 1ps
module wasws_queue #(
	parameter int DATA_BITS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic [DATA_BITS-1:0] push_data,
	output logic                 full,
	input  logic                 pop,
	output logic                 not_empty,
	output logic [DATA_BITS-1:0] pop_data
);

	logic [DATA_BITS-1:0] mem_q [0:1];
	logic                 wr_ptr_q;
	logic                 rd_ptr_q;
	logic [1:0]           count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// ===== rtl/core/wasws_back.sv =====
// Execute pipeline: combinational ops, product, one quotient bit per stage, output register.
`timescale 1ns / 1ps
module wasws_back #(
	parameter int WORD_BITS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_pop,
	input  wasws_pkg::ctrl_t        ctrl,
	input  logic [WORD_BITS-1:0]    operand_a,
	input  logic [WORD_BITS-1:0]    operand_b,
	input  logic [WORD_BITS-1:0]    fill_in,
	input  logic [WORD_BITS-1:0]    spill_in,
	input  logic [wasws_pkg::COUNT_BITS-1:0] shift_amt,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [WORD_BITS-1:0]    result_main,
	output logic [WORD_BITS-1:0]    result_extra,
	output logic [2:0]              status,
	output logic [1:0]              order
);

	localparam int W = WORD_BITS;

	logic             adv;
	logic [W-1:0]     m0, x0;
	logic [2:0]       st0;
	logic [1:0]       ord0;
	logic [W:0]       sum;
	logic [2*W-1:0]   prod;
	logic [2*W-1:0]   shl_m, shl_x, shr_m, shr_x;
	logic [W-1:0]     fill_eff;

	logic             valid_s [0:W];
	wasws_pkg::ctrl_t ctrl_s  [0:W];
	logic [W-1:0]     main_s  [0:W];
	logic [W-1:0]     extra_s [0:W];
	logic [2:0]       st_s    [0:W];
	logic [1:0]       ord_s   [0:W];
	logic [W-1:0]     dvd_s   [0:W];
	logic [W-1:0]     dvs_s   [0:W];
	logic [W-1:0]     rem_s   [0:W];
	logic [W-1:0]     quo_s   [0:W];

	logic [W-1:0]     main_f, extra_f;
	logic [2:0]       st_f;

	assign adv    = !m_tvalid || m_tready;
	assign in_pop = in_valid && adv;

	always_comb begin
		fill_eff = (ctrl.op == wasws_pkg::OP_SAR) ? {W{operand_a[W-1]}} : fill_in;
		sum      = {1'b0, operand_a} + {1'b0, operand_b};
		prod     = {{W{1'b0}}, operand_a} * {{W{1'b0}}, operand_b};
		shl_m    = {operand_a, fill_eff} << shift_amt;
		shl_x    = {spill_in, operand_a} << shift_amt;
		shr_m    = {fill_eff, operand_a} >> shift_amt;
		shr_x    = {operand_a, spill_in} >> shift_amt;
		m0   = '0;
		x0   = '0;
		st0  = wasws_pkg::ST_OK;
		ord0 = wasws_pkg::ORD_LESS;
		case (ctrl.op)
			wasws_pkg::OP_AND: m0 = operand_a & operand_b;
			wasws_pkg::OP_OR:  m0 = operand_a | operand_b;
			wasws_pkg::OP_NOT: m0 = ~operand_a;
			wasws_pkg::OP_NEG: m0 = ~operand_a + W'(1);
			wasws_pkg::OP_CMP: begin
				if (operand_a < operand_b) begin
					ord0 = wasws_pkg::ORD_LESS;
				end else if (operand_a > operand_b) begin
					ord0 = wasws_pkg::ORD_GREATER;
				end else begin
					ord0 = wasws_pkg::ORD_EQUAL;
				end
			end
			wasws_pkg::OP_ADD: begin
				m0  = sum[W-1:0];
				st0 = sum[W] ? wasws_pkg::ST_CARRY : wasws_pkg::ST_OK;
			end
			wasws_pkg::OP_SUB: begin
				m0  = operand_a - operand_b;
				st0 = (operand_a < operand_b) ? wasws_pkg::ST_BORROW : wasws_pkg::ST_OK;
			end
			wasws_pkg::OP_MUL: begin
				m0  = prod[W-1:0];
				x0  = prod[2*W-1:W];
				st0 = (prod[2*W-1:W] != '0) ? wasws_pkg::ST_TWOWORD : wasws_pkg::ST_ONEWORD;
			end
			wasws_pkg::OP_SHL: begin
				if (ctrl.cnt_err) begin
					st0 = wasws_pkg::ST_COUNT;
				end else begin
					m0 = shl_m[2*W-1:W];
					x0 = shl_x[2*W-1:W];
				end
			end
			wasws_pkg::OP_SHR, wasws_pkg::OP_SAR: begin
				if (ctrl.cnt_err) begin
					st0 = wasws_pkg::ST_COUNT;
				end else begin
					m0 = shr_m[W-1:0];
					x0 = shr_x[W-1:0];
				end
			end
			default: begin
				m0 = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else if (adv) begin
			valid_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctrl_s[0]  <= ctrl;
			main_s[0]  <= m0;
			extra_s[0] <= x0;
			st_s[0]    <= st0;
			ord_s[0]   <= ord0;
			dvd_s[0]   <= operand_a;
			dvs_s[0]   <= operand_b;
			rem_s[0]   <= '0;
			quo_s[0]   <= '0;
		end
	end

	for (genvar k = 1; k <= W; k++) begin : g_div
		logic [W:0] trial;
		logic       fits;

		assign trial = {rem_s[k-1], dvd_s[k-1][W-1]};
		assign fits  = trial >= {1'b0, dvs_s[k-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (adv) begin
				valid_s[k] <= valid_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				ctrl_s[k]  <= ctrl_s[k-1];
				main_s[k]  <= main_s[k-1];
				extra_s[k] <= extra_s[k-1];
				st_s[k]    <= st_s[k-1];
				ord_s[k]   <= ord_s[k-1];
				dvd_s[k]   <= {dvd_s[k-1][W-2:0], 1'b0};
				dvs_s[k]   <= dvs_s[k-1];
				rem_s[k]   <= fits ? W'(trial - {1'b0, dvs_s[k-1]}) : trial[W-1:0];
				quo_s[k]   <= {quo_s[k-1][W-2:0], fits};
			end
		end
	end

	always_comb begin
		main_f  = main_s[W];
		extra_f = extra_s[W];
		st_f    = st_s[W];
		case (ctrl_s[W].op)
			wasws_pkg::OP_DIV: begin
				main_f  = ctrl_s[W].zero_div ? '0 : quo_s[W];
				extra_f = ctrl_s[W].zero_div ? '0 : rem_s[W];
				st_f    = ctrl_s[W].zero_div ? wasws_pkg::ST_DIVZ : wasws_pkg::ST_OK;
			end
			wasws_pkg::OP_MOD: begin
				main_f  = '0;
				extra_f = ctrl_s[W].zero_div ? '0 : rem_s[W];
				st_f    = ctrl_s[W].zero_div ? wasws_pkg::ST_MODZ : wasws_pkg::ST_OK;
			end
			default: begin
				main_f = main_s[W];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv) begin
			m_tvalid <= valid_s[W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_main  <= main_f;
			result_extra <= extra_f;
			status       <= st_f;
			order        <= ord_s[W];
		end
	end

endmodule

// ===== rtl/core/word_alu_with_shift_spill.sv =====
// Top level of the word ALU with shift spill.
//
// Input stream s_*: one operation per transfer (mode, two operands, fill word,
// spill word, shift amount). Output stream m_*: one result per transfer (main word,
// extra word, status, compare order), in the order the operations arrived.
// Every mode takes the same path, set by the divide pipeline that retires one
// quotient bit per stage, so results stay in order.
// Throughput: one operation per cycle while m_tready stays high.
// A two-entry queue sits between the decode side and the execute pipeline.
// When m_tvalid is high and m_tready is low the pipeline holds; s_tready drops once the queue fills.
// Reset clears the queue and all valid flags; no results are pending afterwards.
// Zero divisors in DIV/MOD mode and shift amounts above WORD_BITS-1 in shift
// modes give an error status with zero result words.
`timescale 1ns / 1ps
module word_alu_with_shift_spill #(
	parameter int WORD_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// mode[3:0], operand_a, operand_b, fill_in, spill_in, shift_amt[5:0], zero pad
	input  logic [((4*WORD_BITS+10+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// result_main, result_extra, status[2:0], order[1:0], zero pad
	output logic [((2*WORD_BITS+5+7)/8)*8-1:0] m_tdata
);

	localparam int W        = WORD_BITS;
	localparam int CB       = wasws_pkg::COUNT_BITS;
	localparam int CTRL_B   = $bits(wasws_pkg::ctrl_t);
	localparam int ITEM_B   = CTRL_B + 4*W + CB;
	localparam int OUT_BITS = ((2*W+5+7)/8)*8;

	logic [3:0]       mode;
	logic [W-1:0]     operand_a, operand_b, fill_in, spill_in;
	logic [CB-1:0]    shift_amt;
	wasws_pkg::ctrl_t ctrl_in, ctrl_q;
	logic             push, full, not_empty, pop;
	logic [ITEM_B-1:0] item_in, item_out;
	logic [W-1:0]     q_a, q_b, q_fill, q_spill;
	logic [CB-1:0]    q_cnt;
	logic [W-1:0]     result_main, result_extra;
	logic [2:0]       status;
	logic [1:0]       order;

	assign mode        = s_tdata[3:0];
	assign operand_a   = s_tdata[4 +: W];
	assign operand_b   = s_tdata[4+W +: W];
	assign fill_in     = s_tdata[4+2*W +: W];
	assign spill_in    = s_tdata[4+3*W +: W];
	assign shift_amt   = s_tdata[4+4*W +: CB];

	wasws_front #(.WORD_BITS(W)) u_front (
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.mode        (mode),
		.operand_b   (operand_b),
		.shift_amt   (shift_amt),
		.q_full      (full),
		.push        (push),
		.ctrl        (ctrl_in)
	);

	assign item_in = {ctrl_in, shift_amt, spill_in, fill_in, operand_b, operand_a};

	wasws_queue #(.DATA_BITS(ITEM_B)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (item_in),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.pop_data  (item_out)
	);

	assign q_a     = item_out[0 +: W];
	assign q_b     = item_out[W +: W];
	assign q_fill  = item_out[2*W +: W];
	assign q_spill = item_out[3*W +: W];
	assign q_cnt   = item_out[4*W +: CB];
	assign ctrl_q  = wasws_pkg::ctrl_t'(item_out[4*W+CB +: CTRL_B]);

	wasws_back #(.WORD_BITS(W)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (not_empty),
		.in_pop       (pop),
		.ctrl         (ctrl_q),
		.operand_a    (q_a),
		.operand_b    (q_b),
		.fill_in      (q_fill),
		.spill_in     (q_spill),
		.shift_amt    (q_cnt),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.result_main  (result_main),
		.result_extra (result_extra),
		.status       (status),
		.order        (order)
	);

	assign m_tdata = OUT_BITS'({order, status, result_extra, result_main});

endmodule
